/* hw/rtl/sonar_ring_min_max_obstacle_top_assert.svh */
// Assertion macros shared by the sonar ring RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef SONAR_RING_MIN_MAX_OBSTACLE_TOP_ASSERT_SVH
`define SONAR_RING_MIN_MAX_OBSTACLE_TOP_ASSERT_SVH

// same-cycle implication
`define SRO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/sro_pkg.sv */
// Shared widths, register indexes and interface structs for the sonar ring block.
// No dependencies.
`timescale 1ns / 1ps
package sro_pkg;

    localparam int IDX_W      = 3;
    localparam int DIST_W     = 14;
    localparam int OFS_W      = 11;
    localparam int RNG_W      = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [DIST_W-1:0] MAX_RANGE_MM     = 14'd10000;
    localparam logic [DIST_W-1:0] THRESHOLD_RESET  = 14'd500;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 1'd1;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic [DIST_W-1:0] min_dist;
        logic [IDX_W-1:0]  min_idx;
        logic              min_vld;
        logic [DIST_W-1:0] max_dist;
        logic [IDX_W-1:0]  max_idx;
        logic              max_vld;
        logic [IDX_W-1:0]  first_idx;
        logic [IDX_W-1:0]  last_idx;
    } scan_res_t;

endpackage

/* hw/rtl/sonar_ring_min_max_obstacle_top.sv */
// Sonar ring min/max and obstacle segment, top level with sequencer and output register.
// Depends on sro_pkg, sro_bank, sro_scan and sonar_ring_min_max_obstacle_top_assert.svh.
`timescale 1ns / 1ps
// Each accepted reading is stored in its side's bank, then the bank is walked one sonar
// per cycle by a single compare unit to find min, max and the front obstacle span; the
// NBL and NBR states read the neighbors of a single-sonar obstacle, and the RNGS and RNGE
// states add the sensor offset to the span endpoints through one shared adder. s_ready
// stays low from accept until the sequencer is back in idle. The result word sits in an
// output register, so the next reading is taken while it waits for m_ready. A reading
// with sonar_index beyond the bank is dropped with no result.
module sonar_ring_min_max_obstacle_top #(
    parameter int SONARS_PER_SIDE  = 5,
    parameter int SAFE_DISTANCE_MM = 2000
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sro_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sro_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_side,
    input  logic [sro_pkg::IDX_W-1:0]      s_sonar_index,
    input  logic [sro_pkg::DIST_W-1:0]     s_distance_mm,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_updated_side,
    output logic [sro_pkg::DIST_W-1:0]     m_min_distance,
    output logic [sro_pkg::IDX_W-1:0]      m_min_index,
    output logic                           m_min_valid,
    output logic [sro_pkg::DIST_W-1:0]     m_max_distance,
    output logic [sro_pkg::IDX_W-1:0]      m_max_index,
    output logic                           m_max_valid,
    output logic [sro_pkg::IDX_W-1:0]      m_obstacle_start_index,
    output logic [sro_pkg::IDX_W-1:0]      m_obstacle_end_index,
    output logic signed [sro_pkg::RNG_W-1:0] m_obstacle_start_range,
    output logic signed [sro_pkg::RNG_W-1:0] m_obstacle_end_range
);
    import sro_pkg::*;
    `include "sonar_ring_min_max_obstacle_top_assert.svh"

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SONARS_PER_SIDE - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_NBL, ST_NBR, ST_RNGS, ST_RNGE, ST_FIN
    } state_t;

    state_t state_reg;

    logic [DIST_W-1:0]       thr_reg;
    logic signed [OFS_W-1:0] ofs_reg;
    logic                    side_reg;
    logic [IDX_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        seg_s_reg, seg_e_reg;
    logic [DIST_W-1:0]       left_reg;
    logic signed [RNG_W-1:0] rng_s_reg, rng_e_reg;
    logic                    m_valid_reg;

    logic                    accept, idx_ok, wr_en, out_load;
    logic [DIST_W-1:0]       dist_sat;
    logic [IDX_W-1:0]        rd_idx;
    logic [DIST_W-1:0]       back_rd, front_rd, sel_rd;
    logic signed [RNG_W-1:0] rng_sum;
    scan_ctl_t               scan_ctl;
    scan_res_t               scan_res;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
            ofs_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_wdata[DIST_W-1:0];
                REG_OFFSET:    ofs_reg <= $signed(cfg_wdata[OFS_W-1:0]);
                default:       ;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign idx_ok   = {1'b0, s_sonar_index} < (IDX_W + 1)'(SONARS_PER_SIDE);
    assign wr_en    = accept && idx_ok;
    assign dist_sat = (s_distance_mm > MAX_RANGE_MM) ? MAX_RANGE_MM : s_distance_mm;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // read address per sequencer step; neighbor reads are clamped at the edges
    always_comb begin
        unique case (state_reg)
            ST_SCAN: rd_idx = cnt_reg;
            ST_NBL:  rd_idx = (scan_res.first_idx == '0) ? '0 : scan_res.first_idx - 1'b1;
            ST_NBR:  rd_idx = (seg_s_reg == LAST_IDX) ? seg_s_reg : seg_s_reg + 1'b1;
            ST_RNGS: rd_idx = seg_s_reg;
            ST_RNGE: rd_idx = seg_e_reg;
            default: rd_idx = '0;
        endcase
    end

    sro_bank #(
        .SONARS_PER_SIDE  (SONARS_PER_SIDE),
        .SAFE_DISTANCE_MM (SAFE_DISTANCE_MM)
    ) u_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_side  (s_side),
        .wr_idx   (s_sonar_index),
        .wr_data  (dist_sat),
        .rd_idx   (rd_idx),
        .back_rd  (back_rd),
        .front_rd (front_rd)
    );

    assign sel_rd         = side_reg ? front_rd : back_rd;
    assign scan_ctl.clear = wr_en;
    assign scan_ctl.step  = (state_reg == ST_SCAN);

    sro_scan #(
        .SONARS_PER_SIDE (SONARS_PER_SIDE)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .cur_idx   (cnt_reg),
        .sel_rd    (sel_rd),
        .front_rd  (front_rd),
        .threshold (thr_reg),
        .res       (scan_res)
    );

    // shared offset adder for both endpoints
    assign rng_sum = $signed({1'b0, front_rd}) + RNG_W'(ofs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (wr_en) begin
                        side_reg  <= s_side;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX) begin
                        state_reg <= ST_NBL;
                    end
                end
                ST_NBL: begin
                    seg_s_reg <= scan_res.first_idx;
                    seg_e_reg <= scan_res.last_idx;
                    left_reg  <= front_rd;
                    state_reg <= ST_NBR;
                end
                ST_NBR: begin
                    if (seg_s_reg == seg_e_reg) begin
                        if (seg_s_reg != '0 && seg_e_reg != LAST_IDX) begin
                            // single interior sonar: widen toward the nearer neighbor
                            if (left_reg > front_rd) begin
                                seg_e_reg <= seg_e_reg + 1'b1;
                            end else begin
                                seg_s_reg <= seg_s_reg - 1'b1;
                            end
                        end else if (seg_e_reg == '0) begin
                            seg_e_reg <= IDX_W'(1);
                        end else begin
                            seg_s_reg <= IDX_W'(SONARS_PER_SIDE - 2);
                        end
                    end
                    state_reg <= ST_RNGS;
                end
                ST_RNGS: begin
                    rng_s_reg <= rng_sum;
                    state_reg <= ST_RNGE;
                end
                ST_RNGE: begin
                    rng_e_reg <= rng_sum;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_load) begin
                        m_updated_side         <= side_reg;
                        m_min_distance         <= scan_res.min_dist;
                        m_min_index            <= scan_res.min_idx;
                        m_min_valid            <= scan_res.min_vld;
                        m_max_distance         <= scan_res.max_dist;
                        m_max_index            <= scan_res.max_idx;
                        m_max_valid            <= scan_res.max_vld;
                        m_obstacle_start_index <= seg_s_reg;
                        m_obstacle_end_index   <= seg_e_reg;
                        m_obstacle_start_range <= rng_s_reg;
                        m_obstacle_end_range   <= rng_e_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;

    `SRO_ASSERT_NXT(a_busy_after_accept, wr_en, !s_ready, "sequencer did not start on a valid word")
    `SRO_ASSERT_NXT(a_drop_bad_index, accept && !idx_ok, s_ready, "out-of-range word not dropped")
    `SRO_ASSERT_IMP(a_segment_order, m_valid, m_obstacle_start_index < m_obstacle_end_index, "obstacle segment not widened")
    `SRO_ASSERT_IMP(a_min_flag, m_valid, m_min_valid == (m_min_distance < MAX_RANGE_MM), "min valid flag mismatch")
    `SRO_ASSERT_IMP(a_max_flag, m_valid, m_max_valid == (m_max_distance != '0), "max valid flag mismatch")

endmodule

/* hw/rtl/sro_bank.sv */
// Back and front reading banks: one write port, one read index for both banks.
// Depends on sro_pkg.
`timescale 1ns / 1ps
module sro_bank #(
    parameter int SONARS_PER_SIDE  = 5,
    parameter int SAFE_DISTANCE_MM = 2000
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic                       wr_side,
    input  logic [sro_pkg::IDX_W-1:0]  wr_idx,
    input  logic [sro_pkg::DIST_W-1:0] wr_data,
    input  logic [sro_pkg::IDX_W-1:0]  rd_idx,
    output logic [sro_pkg::DIST_W-1:0] back_rd,
    output logic [sro_pkg::DIST_W-1:0] front_rd
);
    import sro_pkg::*;

    localparam int IW = (SONARS_PER_SIDE > 1) ? $clog2(SONARS_PER_SIDE) : 1;

    logic [DIST_W-1:0] back_reg  [SONARS_PER_SIDE];
    logic [DIST_W-1:0] front_reg [SONARS_PER_SIDE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SONARS_PER_SIDE; i++) begin
                back_reg[i]  <= DIST_W'(SAFE_DISTANCE_MM);
                front_reg[i] <= DIST_W'(SAFE_DISTANCE_MM);
            end
        end else if (wr_en) begin
            if (wr_side) begin
                front_reg[wr_idx[IW-1:0]] <= wr_data;
            end else begin
                back_reg[wr_idx[IW-1:0]] <= wr_data;
            end
        end
    end

    assign back_rd  = back_reg[rd_idx[IW-1:0]];
    assign front_rd = front_reg[rd_idx[IW-1:0]];

endmodule

/* hw/rtl/sro_scan.sv */
// Walk unit: one compare step per cycle while ctl.step is set, for min, max and first/last below threshold.
// Depends on sro_pkg.
`timescale 1ns / 1ps
module sro_scan #(
    parameter int SONARS_PER_SIDE = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sro_pkg::scan_ctl_t         ctl,
    input  logic [sro_pkg::IDX_W-1:0]  cur_idx,
    input  logic [sro_pkg::DIST_W-1:0] sel_rd,
    input  logic [sro_pkg::DIST_W-1:0] front_rd,
    input  logic [sro_pkg::DIST_W-1:0] threshold,
    output sro_pkg::scan_res_t         res
);
    import sro_pkg::*;

    scan_res_t res_reg, res_next;
    logic      found_reg, found_next;
    logic      below;

    assign below = front_rd < threshold;

    always_comb begin
        res_next   = res_reg;
        found_next = found_reg;
        if (ctl.clear) begin
            res_next.min_dist  = MAX_RANGE_MM;
            res_next.min_idx   = '0;
            res_next.min_vld   = 1'b0;
            res_next.max_dist  = '0;
            res_next.max_idx   = '0;
            res_next.max_vld   = 1'b0;
            res_next.first_idx = '0;
            res_next.last_idx  = IDX_W'(SONARS_PER_SIDE - 1);
            found_next         = 1'b0;
        end else if (ctl.step) begin
            if (sel_rd < res_reg.min_dist) begin
                res_next.min_dist = sel_rd;
                res_next.min_idx  = cur_idx;
                res_next.min_vld  = 1'b1;
            end
            if (sel_rd > res_reg.max_dist) begin
                res_next.max_dist = sel_rd;
                res_next.max_idx  = cur_idx;
                res_next.max_vld  = 1'b1;
            end
            if (below) begin
                res_next.last_idx = cur_idx;
                if (!found_reg) begin
                    res_next.first_idx = cur_idx;
                    found_next         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg       <= 1'b0;
            res_reg.min_vld <= 1'b0;
            res_reg.max_vld <= 1'b0;
        end else begin
            found_reg       <= found_next;
            res_reg.min_vld <= res_next.min_vld;
            res_reg.max_vld <= res_next.max_vld;
        end
        res_reg.min_dist  <= res_next.min_dist;
        res_reg.min_idx   <= res_next.min_idx;
        res_reg.max_dist  <= res_next.max_dist;
        res_reg.max_idx   <= res_next.max_idx;
        res_reg.first_idx <= res_next.first_idx;
        res_reg.last_idx  <= res_next.last_idx;
    end

    assign res = res_reg;

endmodule
